FILE: rtl/stream_string_replace_unit_macros.svh
// Assertion macros used by the checker of the string replace unit.
`ifndef STREAM_STRING_REPLACE_UNIT_MACROS_SVH
`define STREAM_STRING_REPLACE_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define SSR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define SSR_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define SSR_ASSERT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ssr_pkg.sv
// Types and constants of the string replace unit.
package ssr_pkg;

   localparam int BYTE_W      = 8;
   localparam int CFG_W       = 64;
   localparam int LEN_W       = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int REPL_IDX_W  = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SEARCH_BYTES       = 2'd0,
      CSR_SEARCH_LENGTH      = 2'd1,
      CSR_REPLACEMENT_BYTES  = 2'd2,
      CSR_REPLACEMENT_LENGTH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              carries_byte;
      logic              subject_end;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] result_byte;
      logic              result_has_byte;
      logic              result_end;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] search_bytes;
      logic [LEN_W-1:0] search_length;
      logic [CFG_W-1:0] replacement_bytes;
      logic [LEN_W-1:0] replacement_length;
   } cfg_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DRAIN,
      BK_EVAL,
      BK_REPL,
      BK_FLUSH,
      BK_DONE
   } back_state_type;

endpackage

FILE: rtl/stream_string_replace_unit.sv
// Streaming find-and-replace-all unit: top level with registers and result queue.
// A word passes the item queue, the match engine and its one-byte stage before its first
// result reaches the result queue, unless its bytes stay held back for a later word.
// The match engine works on one word at a time and takes the next only after it has emitted
// the released or replacement bytes of the last; a full result queue stalls it.
// Reset is synchronous and active high: queues empty, no bytes held, registers zero.
module stream_string_replace_unit import ssr_pkg::*; #(
   parameter int MAX_SEARCH_BYTES   = 8,
   parameter int MAX_REPLACE_BYTES  = 8,
   parameter int ITEM_QUEUE_DEPTH   = 2,
   parameter int RESULT_QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  req_type                req_data,
   output logic                   empty,
   input  logic                   pop,
   output rsp_type                rsp_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   req_type q_data;
   logic    q_empty, q_pop;
   logic    out_full, out_push;
   rsp_type out_data, out_rd;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_SEARCH_BYTES:       cfg_in.search_bytes       = csr_wdata;
            CSR_SEARCH_LENGTH:      cfg_in.search_length      = csr_wdata[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES:  cfg_in.replacement_bytes  = csr_wdata;
            CSR_REPLACEMENT_LENGTH: cfg_in.replacement_length = csr_wdata[LEN_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ssr_front #(
      .QUEUE_DEPTH (ITEM_QUEUE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_pop    (q_pop),
      .q_data   (q_data),
      .q_empty  (q_empty)
   );

   ssr_back #(
      .MAX_SEARCH_BYTES  (MAX_SEARCH_BYTES),
      .MAX_REPLACE_BYTES (MAX_REPLACE_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_empty  (q_empty),
      .q_data   (q_data),
      .q_pop    (q_pop),
      .out_full (out_full),
      .out_push (out_push),
      .out_data (out_data)
   );

   ssr_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RESULT_QUEUE_DEPTH)
   ) u_result_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (out_push),
      .wr_data (out_data),
      .rd_en   (pop),
      .rd_data (out_rd),
      .full    (out_full),
      .empty   (empty)
   );

   assign rsp_data = out_rd;

endmodule

FILE: rtl/ssr_fifo.sv
// Small register-based first-in first-out queue.
module ssr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wptr_ff, wptr_in;
   logic [AW-1:0]    rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_wr) begin
         wptr_in = (wptr_ff == AW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_rd) begin
         rptr_in = (rptr_ff == AW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

endmodule

FILE: rtl/ssr_front.sv
// Input side: takes words, drops bare words that close nothing, and queues the rest.
module ssr_front import ssr_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   input  logic    q_pop,
   output req_type q_data,
   output logic    q_empty
);

   logic    keep;
   logic    q_full;
   req_type q_rd;

   // A word with neither a byte nor an end mark has no effect at all.
   assign keep    = req_data.carries_byte || req_data.subject_end;
   assign full    = q_full;
   assign q_data  = q_rd;

   ssr_fifo #(
      .WIDTH ($bits(req_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push && !q_full && keep),
      .wr_data (req_data),
      .rd_en   (q_pop),
      .rd_data (q_rd),
      .full    (q_full),
      .empty   (q_empty)
   );

endmodule

FILE: rtl/ssr_back.sv
// Match engine: holds pending bytes, releases them or emits the replacement.
module ssr_back import ssr_pkg::*; #(
   parameter int MAX_SEARCH_BYTES  = 8,
   parameter int MAX_REPLACE_BYTES = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    q_empty,
   input  req_type q_data,
   output logic    q_pop,
   input  logic    out_full,
   output logic    out_push,
   output rsp_type out_data
);

   localparam int CNT_W  = $clog2(MAX_SEARCH_BYTES + 1);
   localparam int HIDX_W = (MAX_SEARCH_BYTES > 1) ? $clog2(MAX_SEARCH_BYTES) : 1;

   back_state_type    state_ff, state_in;
   logic [BYTE_W-1:0] held_ff [MAX_SEARCH_BYTES];
   logic [BYTE_W-1:0] held_in [MAX_SEARCH_BYTES];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] cur_byte_ff, cur_byte_in;
   logic              cur_end_ff, cur_end_in;
   logic [REPL_IDX_W-1:0] ridx_ff, ridx_in;
   logic              stage_valid_ff, stage_valid_in;
   logic [BYTE_W-1:0] stage_byte_ff, stage_byte_in;

   logic [LEN_W-1:0]  slen, rlen;
   logic              prefix_ok, full_match, can_emit, repl_last;
   logic              emit, shift, append, clear;
   logic [BYTE_W-1:0] emit_byte;
   back_state_type    after_state;

   assign slen = (cfg.search_length > LEN_W'(MAX_SEARCH_BYTES)) ?
                 LEN_W'(MAX_SEARCH_BYTES) : cfg.search_length;
   assign rlen = (cfg.replacement_length > LEN_W'(MAX_REPLACE_BYTES)) ?
                 LEN_W'(MAX_REPLACE_BYTES) : cfg.replacement_length;

   // The stage keeps back one byte until a word is done so a subject's end can be marked.
   assign can_emit    = !stage_valid_ff || !out_full;
   assign full_match  = (LEN_W'(count_ff) == slen);
   assign repl_last   = ((LEN_W'(ridx_ff) + 1'b1) == rlen);
   assign after_state = cur_end_ff ? BK_FLUSH : BK_DONE;

   always_comb begin
      prefix_ok = (LEN_W'(count_ff) <= slen);
      for (int i = 0; i < MAX_SEARCH_BYTES; i++) begin
         if ((CNT_W'(i) < count_ff) &&
             (held_ff[i] != cfg.search_bytes[i*BYTE_W +: BYTE_W])) begin
            prefix_ok = 1'b0;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               if (!q_data.carries_byte) begin
                  state_in = BK_FLUSH;
               end else if (slen == '0) begin
                  state_in = BK_DRAIN;
               end else begin
                  state_in = BK_EVAL;
               end
            end
         end
         BK_DRAIN: begin
            if (can_emit && count_ff == '0) begin
               state_in = BK_DONE;
            end
         end
         BK_EVAL: begin
            if (count_ff == '0) begin
               state_in = after_state;
            end else if (prefix_ok) begin
               if (full_match && rlen != '0) begin
                  state_in = BK_REPL;
               end else begin
                  state_in = after_state;
               end
            end
         end
         BK_REPL: begin
            if (can_emit && repl_last) begin
               state_in = after_state;
            end
         end
         BK_FLUSH: begin
            if (count_ff == '0) begin
               state_in = BK_DONE;
            end else if (can_emit && count_ff == CNT_W'(1)) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (!out_full || (!cur_end_ff && !stage_valid_ff)) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      q_pop          = 1'b0;
      emit           = 1'b0;
      emit_byte      = held_ff[0];
      shift          = 1'b0;
      append         = 1'b0;
      clear          = 1'b0;
      ridx_in        = ridx_ff;
      cur_byte_in    = cur_byte_ff;
      cur_end_in     = cur_end_ff;
      out_push       = 1'b0;
      out_data       = '0;
      stage_valid_in = stage_valid_ff;
      stage_byte_in  = stage_byte_ff;

      unique case (state_ff)
         BK_IDLE: begin
            q_pop = !q_empty;
            if (!q_empty) begin
               cur_byte_in = q_data.text_byte;
               cur_end_in  = q_data.subject_end;
               append      = q_data.carries_byte && (slen != '0);
            end
         end
         BK_DRAIN: begin
            if (can_emit) begin
               emit = 1'b1;
               if (count_ff != '0) begin
                  shift = 1'b1;
               end else begin
                  emit_byte = cur_byte_ff;
               end
            end
         end
         BK_EVAL: begin
            if (count_ff != '0) begin
               if (prefix_ok) begin
                  if (full_match) begin
                     clear   = 1'b1;
                     ridx_in = '0;
                  end
               end else if (can_emit) begin
                  emit  = 1'b1;
                  shift = 1'b1;
               end
            end
         end
         BK_REPL: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_byte = cfg.replacement_bytes[{ridx_ff, 3'b000} +: BYTE_W];
               ridx_in   = ridx_ff + 1'b1;
            end
         end
         BK_FLUSH: begin
            if (count_ff != '0 && can_emit) begin
               emit  = 1'b1;
               shift = 1'b1;
            end
         end
         BK_DONE: begin
            if (!out_full) begin
               if (cur_end_ff) begin
                  out_push                 = 1'b1;
                  out_data.result_byte     = stage_valid_ff ? stage_byte_ff : '0;
                  out_data.result_has_byte = stage_valid_ff;
                  out_data.result_end      = 1'b1;
                  stage_valid_in           = 1'b0;
               end else if (stage_valid_ff) begin
                  out_push                 = 1'b1;
                  out_data.result_byte     = stage_byte_ff;
                  out_data.result_has_byte = 1'b1;
                  stage_valid_in           = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase

      if (emit) begin
         if (stage_valid_ff) begin
            out_push                 = 1'b1;
            out_data.result_byte     = stage_byte_ff;
            out_data.result_has_byte = 1'b1;
         end
         stage_valid_in = 1'b1;
         stage_byte_in  = emit_byte;
      end
   end

   always_comb begin
      held_in  = held_ff;
      count_in = count_ff;
      if (shift) begin
         for (int i = 0; i < MAX_SEARCH_BYTES - 1; i++) begin
            held_in[i] = held_ff[i+1];
         end
         count_in = count_ff - 1'b1;
      end
      if (append) begin
         held_in[count_ff[HIDX_W-1:0]] = q_data.text_byte;
         count_in = count_ff + 1'b1;
      end
      if (clear) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= BK_IDLE;
         count_ff       <= '0;
         stage_valid_ff <= 1'b0;
         cur_end_ff     <= 1'b0;
         ridx_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         stage_valid_ff <= stage_valid_in;
         cur_end_ff     <= cur_end_in;
         ridx_ff        <= ridx_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff       <= held_in;
      cur_byte_ff   <= cur_byte_in;
      stage_byte_ff <= stage_byte_in;
   end

endmodule

FILE: rtl/ssr_checker.sv
// Port-level checks of the string replace unit, bound to the top level.
`include "stream_string_replace_unit_macros.svh"

module ssr_checker import ssr_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    push,
   input logic    full,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_data
);

   // Both queues come out of reset empty.
   `SSR_ASSERT_RST(a_reset_empty, reset, empty && !full, "queues not empty after reset")

   // A word without a byte is only ever the empty end of a string.
   `SSR_ASSERT_IMP(a_bare_is_end, !empty && !rsp_data.result_has_byte, rsp_data.result_end && rsp_data.result_byte == '0, "bare result word is not an empty end")

   // A waiting result holds until it is taken.
   `SSR_ASSERT_NXT(a_result_holds, !empty && !pop, !empty && $stable(rsp_data), "waiting result changed")

   // Straight out of reset, results only appear after some input has been taken.
   `SSR_ASSERT_NXT(a_no_invented, $past(reset) && empty && !(push && !full), empty, "result appeared without input")

endmodule

bind stream_string_replace_unit ssr_checker u_ssr_checker (.*);

FILE: tb/stream_string_replace_unit_tb.sv
// Testbench for the string replace unit: directed and random text checked against a predictor.
`timescale 1ns / 100ps

module stream_string_replace_unit_tb;
   import ssr_pkg::*;

   localparam int HELD_MAX      = 8;
   localparam int REPL_MAX      = 8;
   localparam int IDLE_PCT      = 38;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASES        = 10;
   localparam int PHASE_WORDS   = 26;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   push      = 1'b0;
   logic                   pop       = 1'b0;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]       csr_wdata = '0;
   req_type                req_data  = '0;
   logic                   full;
   logic                   empty;
   rsp_type                rsp_data;

   // Predictor state: active register values and the bytes held as a search prefix.
   cfg_type     active_cfg = '0;
   logic [7:0]  held [HELD_MAX];
   int          held_n = 0;

   req_type     text_words[$];
   rsp_type     expected_words[$];
   rsp_type     oldest;
   bit          steady = 1'b0;
   int          mismatches = 0;
   int          items_accepted = 0;
   int          words_checked = 0;
   int          settings_used = 0;

   stream_string_replace_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic int clamp_len(input logic [LEN_W-1:0] len, input int cap);
      return (int'(len) > cap) ? cap : int'(len);
   endfunction

   function automatic void emit_byte(input logic [7:0] b);
      expected_words.push_back(rsp_type'{result_byte: b, result_has_byte: 1'b1,
                                         result_end: 1'b0});
   endfunction

   function automatic void release_oldest();
      emit_byte(held[0]);
      for (int i = 1; i < held_n; i++)
         held[i-1] = held[i];
      held_n--;
   endfunction

   function automatic int flush_held();
      int n;
      n = 0;
      while (held_n > 0) begin
         release_oldest();
         n++;
      end
      return n;
   endfunction

   function automatic bit held_matches(input int slen);
      if (held_n > slen)
         return 1'b0;
      for (int i = 0; i < held_n; i++)
         if (held[i] != active_cfg.search_bytes[8*i +: 8])
            return 1'b0;
      return 1'b1;
   endfunction

   // Works out every result word that one accepted text word causes.
   function automatic void predict_replace(input req_type w);
      int      slen;
      int      rlen;
      int      n;
      rsp_type tail;
      slen = clamp_len(active_cfg.search_length, HELD_MAX);
      rlen = clamp_len(active_cfg.replacement_length, REPL_MAX);
      n = 0;
      if (w.carries_byte) begin
         if (slen == 0) begin
            n += flush_held();
            emit_byte(w.text_byte);
            n++;
         end else begin
            if (held_n < HELD_MAX) begin
               held[held_n] = w.text_byte;
               held_n++;
            end
            // Drop bytes from the front until what is left is still a prefix.
            while (held_n > 0) begin
               if (held_matches(slen)) begin
                  if (held_n == slen) begin
                     for (int i = 0; i < rlen; i++)
                        emit_byte(active_cfg.replacement_bytes[8*i +: 8]);
                     n += rlen;
                     held_n = 0;
                  end
                  break;
               end
               release_oldest();
               n++;
            end
         end
      end
      if (w.subject_end) begin
         n += flush_held();
         if (n > 0) begin
            tail = expected_words.pop_back();
            tail.result_end = 1'b1;
            expected_words.push_back(tail);
         end else begin
            expected_words.push_back(rsp_type'{result_byte: 8'h00, result_has_byte: 1'b0,
                                               result_end: 1'b1});
         end
      end
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Result check first, then prediction of the word taken at this edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) begin
            words_checked++;
            if (expected_words.size() == 0) begin
               $display("%0t ns: unexpected word, expected none, actual %h", $time, rsp_data);
               mismatches++;
            end else begin
               oldest = expected_words.pop_front();
               check_field("result_byte", oldest.result_byte, rsp_data.result_byte);
               check_field("result_has_byte", oldest.result_has_byte, rsp_data.result_has_byte);
               check_field("result_end", oldest.result_end, rsp_data.result_end);
            end
         end
         if (push && !full) begin
            items_accepted++;
            predict_replace(req_data);
            void'(text_words.pop_front());
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && text_words.size() > 0 &&
          (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
         push     <= 1'b1;
         req_data <= text_words[0];
      end else begin
         push <= 1'b0;
      end
      pop <= !reset && (steady || $urandom_range(0, 99) >= IDLE_PCT);
   end

   task automatic queue_word(input logic [7:0] b, input bit has, input bit fin);
      text_words.push_back(req_type'{text_byte: b, carries_byte: has, subject_end: fin});
   endtask

   // Queues the low bytes of a string, first byte in the low bits.
   task automatic queue_string(input logic [63:0] s, input int count, input bit close);
      for (int i = 0; i < count; i++)
         queue_word(s[8*i +: 8], 1'b1, close && (i == count - 1));
   endtask

   task automatic wait_idle();
      while (text_words.size() != 0 || expected_words.size() != 0)
         @(posedge clock);
      // Held bytes give no result, so let the engine settle before a register write.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_config(input logic [63:0] sbytes, input logic [3:0] slen,
                              input logic [63:0] rbytes, input logic [3:0] rlen);
      logic [63:0] junk;
      junk = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'h0;
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_SEARCH_BYTES;
      csr_wdata <= sbytes;
      @(negedge clock);
      csr_index <= CSR_SEARCH_LENGTH;
      csr_wdata <= {junk[63:4], slen};
      @(negedge clock);
      csr_index <= CSR_REPLACEMENT_BYTES;
      csr_wdata <= rbytes;
      @(negedge clock);
      csr_index <= CSR_REPLACEMENT_LENGTH;
      csr_wdata <= {~junk[63:4], rlen};
      @(negedge clock);
      csr_write <= 1'b0;
      active_cfg.search_bytes       = sbytes;
      active_cfg.search_length      = slen;
      active_cfg.replacement_bytes  = rbytes;
      active_cfg.replacement_length = rlen;
      settings_used++;
   endtask

   function automatic logic [3:0] pick_len();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0)
         return 4'd0;
      else if (roll == 8)
         return 4'd8;
      else if (roll == 9)
         return 4'($urandom_range(9, 15));
      return 4'($urandom_range(1, 8));
   endfunction

   initial begin
      logic [7:0]  alphabet [3];
      logic [63:0] sbytes;
      int          slen;
      int          count;
      int          roll;
      int          k;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Pass-through at reset values, an empty subject and a bare word without end.
      queue_word(8'h00, 1'b1, 1'b0);
      queue_word(8'hFF, 1'b1, 1'b1);
      queue_word(8'h00, 1'b0, 1'b1);
      queue_word(8'hA5, 1'b0, 1'b0);
      queue_word(8'h5A, 1'b1, 1'b1);
      wait_idle();

      // "ab" becomes "XYZ" inside "xaababb", with a false start on the first a.
      load_config(64'h6261, 4'd2, 64'h5A5958, 4'd3);
      queue_string(64'h0062_6261_6261_6178, 7, 1'b1);
      wait_idle();

      // Oversized lengths saturate; zero bytes match like any other byte.
      load_config(64'h0, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
      queue_string(64'h0, 8, 1'b0);
      queue_word(8'h00, 1'b0, 1'b1);
      wait_idle();

      // A subject that is wholly deleted still closes with an empty end word.
      load_config(64'h61, 4'd1, 64'h0, 4'd0);
      queue_string(64'h6161, 2, 1'b1);
      wait_idle();

      // Bytes held under one search string are released when searching is turned off.
      load_config(64'h636261, 4'd3, 64'h21, 4'd1);
      queue_string(64'h6261, 2, 1'b0);
      wait_idle();
      load_config(64'h636261, 4'd0, 64'h21, 4'd1);
      queue_word(8'h7A, 1'b1, 1'b1);
      wait_idle();

      for (int phase = 0; phase < PHASES; phase++) begin
         steady = (phase == 4);
         for (k = 0; k < 3; k++)
            alphabet[k] = 8'($urandom_range(0, 255));
         if (phase % 3 == 0)
            alphabet[0] = 8'h00;
         if (phase % 3 == 1)
            alphabet[1] = 8'hFF;
         for (k = 0; k < 8; k++)
            sbytes[8*k +: 8] = alphabet[$urandom_range(0, 2)];
         load_config(sbytes, pick_len(), {$urandom, $urandom}, pick_len());
         slen = clamp_len(active_cfg.search_length, HELD_MAX);
         count = 0;
         // Mostly text built from a small alphabet and copies of the search string.
         while (count < PHASE_WORDS) begin
            roll = $urandom_range(0, 99);
            if (roll < 30 && slen > 0) begin
               k = $urandom_range(0, 1) ? slen : $urandom_range(1, slen);
               queue_string(active_cfg.search_bytes, k, 1'b0);
               count += k;
            end else begin
               if (roll < 80)
                  queue_word(alphabet[$urandom_range(0, 2)], 1'b1, 1'b0);
               else if (roll < 90)
                  queue_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
               else if (roll < 96)
                  queue_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
               else
                  queue_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
               count++;
            end
         end
         // Some phases leave bytes held so the next setting applies mid-subject.
         if ($urandom_range(0, 9) < 7)
            queue_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
         wait_idle();
      end
      steady = 1'b0;
      queue_word(8'h00, 1'b0, 1'b1);
      wait_idle();

      $display("Covered %0d text words under %0d register settings, %0d result words checked.",
               items_accepted, settings_used, words_checked);
      $display("Mismatches found: %0d", mismatches);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
